@@ rtl/ftbm_pkg.sv @@
// shared types and constants of the frame time budget monitor
`timescale 1ns / 1ps

package ftbm_pkg;

    // fixed field widths at the block boundary
    localparam int OUT_W    = 24;
    localparam int TARGET_W = 24;
    localparam int ALPHA_W  = 16;
    localparam int CFG_W    = 24;
    localparam int IDX_W    = 1;

    // register values after reset
    localparam logic [TARGET_W-1:0] TARGET_RESET = 24'd16667;
    localparam logic [ALPHA_W-1:0]  ALPHA_RESET  = 16'd6554;

    // configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_TARGET = 1'b0,
        REG_ALPHA  = 1'b1
    } ftbm_reg_idx_t;

    // request operation codes
    typedef enum logic {
        OP_FRAME = 1'b0,
        OP_CLEAR = 1'b1
    } ftbm_op_t;

    // configuration register contents
    typedef struct packed {
        logic [TARGET_W-1:0] target;
        logic [ALPHA_W-1:0]  alpha;
    } ftbm_cfg_t;

    // sequencer states
    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_DIFF  = 7'b0000010,
        ST_DNEG  = 7'b0000100,
        ST_MUL   = 7'b0001000,
        ST_RATIO = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_FIN   = 7'b1000000
    } ftbm_state_t;

endpackage

@@ rtl/ftbm_alu.sv @@
// shared add and subtract unit with carry out
`timescale 1ns / 1ps

module ftbm_alu #(
    parameter int W = 56
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic         sub,
    output logic [W-1:0] y,
    output logic         carry
);

    logic [W-1:0] b_eff;

    // a - b is a + ~b + 1; carry set means no borrow
    assign b_eff = sub ? ~b : b;
    assign {carry, y} = {1'b0, a} + {1'b0, b_eff} + {{W{1'b0}}, sub};

endmodule

@@ rtl/ftbm_cfg.sv @@
// configuration registers: frame budget and average weight
`timescale 1ns / 1ps

module ftbm_cfg
    import ftbm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata,
    output ftbm_cfg_t        cfg
);

    ftbm_cfg_t cfg_reg;

    // register write decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target <= TARGET_RESET;
            cfg_reg.alpha  <= ALPHA_RESET;
        end
        else if (cfg_we)
        begin
            case (ftbm_reg_idx_t'(cfg_index))
                REG_TARGET: cfg_reg.target <= cfg_wdata[TARGET_W-1:0];
                REG_ALPHA:  cfg_reg.alpha  <= cfg_wdata[ALPHA_W-1:0];
                default:    ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/frame_time_budget_monitor_core.sv @@
// frame time budget monitor: statistics, moving average and budget ratio
// steps: difference, multiply, ratio, divide; a clear or first average load
//   starts at the ratio step; a saturated ratio or zero budget skips the divide
// requests: one at a time, set by the multiply and divide sharing
//   one adder; the next request is taken once the result is registered
// reset: statistics zero, target 16667, alpha 6554, no response pending
`timescale 1ns / 1ps

module frame_time_budget_monitor_core
    import ftbm_pkg::*;
#(
    parameter int TIME_BITS       = 24,
    parameter int ALPHA_FRAC_BITS = 16,
    parameter int RATIO_FRAC_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    // configuration
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata,
    // request channel
    input  logic             req_valid,
    output logic             req_stall,
    input  logic             operation,
    input  logic [OUT_W-1:0] frame_time,
    // response channel
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output logic             over_budget,
    output logic [OUT_W-1:0] last_duration,
    output logic [OUT_W-1:0] average_time,
    output logic [OUT_W-1:0] worst_time,
    output logic [OUT_W-1:0] undershoot,
    output logic [OUT_W-1:0] overshoot,
    output logic [OUT_W-1:0] pressure_ratio
);

    localparam int T        = TIME_BITS;
    localparam int F        = ALPHA_FRAC_BITS;
    localparam int R        = RATIO_FRAC_BITS;
    localparam int AW       = T + F;
    localparam int W        = T + 2 * F;
    localparam int NW       = T + R;
    localparam int SW       = 2 * T + R;
    localparam int STEP_MAX = (T > F) ? T : F;
    localparam int CNT_W    = $clog2(STEP_MAX);

    ftbm_cfg_t   cfg;
    ftbm_state_t state_reg;
    ftbm_state_t state_next;

    logic [T-1:0]     target;
    logic [F-1:0]     alpha;
    logic [T-1:0]     x_in;

    // statistics
    logic [T-1:0]     last_reg;
    logic [T-1:0]     worst_reg;
    logic [AW-1:0]    acc_reg;
    logic             flag_reg;

    // working registers of the shared unit
    logic [W-1:0]     work_reg;
    logic [W-1:0]     d_reg;
    logic             neg_reg;
    logic [F-1:0]     alpha_sh_reg;
    logic [T-1:0]     num_sh_reg;
    logic [T-1:0]     quo_reg;
    logic [CNT_W-1:0] cnt_reg;

    // response register
    logic             rsp_valid_reg;
    logic             over_budget_reg;
    logic [OUT_W-1:0] last_duration_reg;
    logic [OUT_W-1:0] average_time_reg;
    logic [OUT_W-1:0] worst_time_reg;
    logic [OUT_W-1:0] undershoot_reg;
    logic [OUT_W-1:0] overshoot_reg;
    logic [OUT_W-1:0] pressure_ratio_reg;

    logic [W-1:0]     alu_a;
    logic [W-1:0]     alu_b;
    logic             alu_sub;
    logic [W-1:0]     alu_y;
    logic             alu_carry;

    logic             req_fire;
    logic             rsp_load;
    logic [AW-1:0]    xf;
    logic [W-1:0]     prod_fin;
    logic [NW-1:0]    num;
    logic [NW-1:0]    num_hi;
    logic             ratio_sat;
    logic [T:0]       rem_shift;
    logic [T-1:0]     under_val;
    logic [T-1:0]     over_val;

    ftbm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ftbm_alu #(
        .W (W)
    ) u_alu (
        .a     (alu_a),
        .b     (alu_b),
        .sub   (alu_sub),
        .y     (alu_y),
        .carry (alu_carry)
    );

    // operand widths at the internal precision
    assign target = T'(cfg.target);
    assign alpha  = F'(cfg.alpha);
    assign x_in   = T'(frame_time);

    assign req_stall = (state_reg != ST_IDLE);
    assign req_fire  = req_valid && !req_stall;
    assign rsp_load  = (state_reg == ST_FIN) && (!rsp_valid_reg || !rsp_stall);

    // derived values for the average and ratio steps
    assign xf        = {last_reg, {F{1'b0}}};
    assign prod_fin  = alpha_sh_reg[0] ? alu_y : work_reg;
    assign num       = {last_reg, {R{1'b0}}};
    assign num_hi    = num >> T;
    assign ratio_sat = SW'(num) >= SW'({target, {T{1'b0}}});
    assign rem_shift = {work_reg[T-1:0], num_sh_reg[T-1]};
    assign under_val = (target > last_reg) ? target - last_reg : '0;
    assign over_val  = (last_reg > target) ? last_reg - target : '0;

    // operand select for the shared adder
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (state_reg)
            ST_DIFF:
            begin
                alu_a   = W'(xf);
                alu_b   = W'(acc_reg);
                alu_sub = 1'b1;
            end
            ST_DNEG:
            begin
                alu_a   = W'(acc_reg);
                alu_b   = W'(xf);
                alu_sub = 1'b1;
            end
            ST_MUL:
            begin
                alu_a   = work_reg;
                alu_b   = d_reg;
                alu_sub = neg_reg;
            end
            ST_DIV:
            begin
                alu_a   = W'(rem_shift);
                alu_b   = W'(target);
                alu_sub = 1'b1;
            end
            default: ;
        endcase
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (operation == OP_CLEAR || acc_reg == '0)
                        state_next = ST_RATIO;
                    else
                        state_next = ST_DIFF;
                end
            end
            ST_DIFF:  state_next = alu_carry ? ST_MUL : ST_DNEG;
            ST_DNEG:  state_next = ST_MUL;
            ST_MUL:   state_next = (cnt_reg == '0) ? ST_RATIO : ST_MUL;
            ST_RATIO:
            begin
                if (target == '0 || ratio_sat)
                    state_next = ST_FIN;
                else
                    state_next = ST_DIV;
            end
            ST_DIV:   state_next = (cnt_reg == '0) ? ST_FIN : ST_DIV;
            ST_FIN:   state_next = rsp_load ? ST_IDLE : ST_FIN;
            default:  state_next = ST_IDLE;
        endcase
    end

    // control state and statistics
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            last_reg      <= '0;
            worst_reg     <= '0;
            acc_reg       <= '0;
            flag_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // statistics update on request
            if (req_fire)
            begin
                if (operation == OP_CLEAR)
                begin
                    last_reg  <= '0;
                    worst_reg <= '0;
                    acc_reg   <= '0;
                    flag_reg  <= 1'b0;
                end
                else
                begin
                    last_reg <= x_in;
                    flag_reg <= (x_in > target);
                    if (x_in > worst_reg)
                        worst_reg <= x_in;
                    if (acc_reg == '0)
                        acc_reg <= {x_in, {F{1'b0}}};
                end
            end
            // average written back after the last multiply step
            if (state_reg == ST_MUL && cnt_reg == '0)
                acc_reg <= prod_fin[W-1:F];
            // response valid
            if (rsp_load)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    // working registers of the multiply and divide
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_DIFF:
            begin
                work_reg     <= W'({acc_reg, {F{1'b0}}});
                alpha_sh_reg <= alpha;
                cnt_reg      <= CNT_W'(F - 1);
                d_reg        <= alu_y;
                neg_reg      <= 1'b0;
            end
            ST_DNEG:
            begin
                d_reg   <= alu_y;
                neg_reg <= 1'b1;
            end
            ST_MUL:
            begin
                work_reg     <= prod_fin;
                d_reg        <= {d_reg[W-2:0], 1'b0};
                alpha_sh_reg <= alpha_sh_reg >> 1;
                cnt_reg      <= cnt_reg - 1'b1;
            end
            ST_RATIO:
            begin
                work_reg   <= W'(num_hi[T-1:0]);
                num_sh_reg <= num[T-1:0];
                cnt_reg    <= CNT_W'(T - 1);
                if (target == '0)
                    quo_reg <= '0;
                else if (ratio_sat)
                    quo_reg <= '1;
                else
                    quo_reg <= '0;
            end
            ST_DIV:
            begin
                work_reg   <= alu_carry ? W'(alu_y[T:0]) : W'(rem_shift);
                quo_reg    <= {quo_reg[T-2:0], alu_carry};
                num_sh_reg <= {num_sh_reg[T-2:0], 1'b0};
                cnt_reg    <= cnt_reg - 1'b1;
            end
            default: ;
        endcase
    end

    // response payload
    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            over_budget_reg    <= flag_reg;
            last_duration_reg  <= OUT_W'(last_reg);
            average_time_reg   <= OUT_W'(acc_reg[AW-1:F]);
            worst_time_reg     <= OUT_W'(worst_reg);
            undershoot_reg     <= OUT_W'(under_val);
            overshoot_reg      <= OUT_W'(over_val);
            pressure_ratio_reg <= OUT_W'(quo_reg);
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign over_budget    = over_budget_reg;
    assign last_duration  = last_duration_reg;
    assign average_time   = average_time_reg;
    assign worst_time     = worst_time_reg;
    assign undershoot     = undershoot_reg;
    assign overshoot      = overshoot_reg;
    assign pressure_ratio = pressure_ratio_reg;

endmodule

@@ rtl/ftbm_checker.sv @@
// port-level checks of the frame time budget monitor and their binding
`timescale 1ns / 1ps

module ftbm_checker
    import ftbm_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_stall,
    input logic             rsp_valid,
    input logic             rsp_stall,
    input logic             over_budget,
    input logic [OUT_W-1:0] last_duration,
    input logic [OUT_W-1:0] worst_time,
    input logic [OUT_W-1:0] undershoot,
    input logic [OUT_W-1:0] overshoot,
    input logic [OUT_W-1:0] pressure_ratio
);

    // a taken request keeps the block busy on the next cycle
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while busy flag low");

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(last_duration)
            && $stable(pressure_ratio) && $stable(over_budget))
        else $error("stalled response changed");

    // worst never below last, flag agrees with overshoot
    a_stats_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> worst_time >= last_duration && over_budget == (overshoot != '0))
        else $error("statistics inconsistent");

    // undershoot and overshoot never both set
    a_shoot_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> undershoot == '0 || overshoot == '0)
        else $error("undershoot and overshoot both nonzero");

endmodule

bind frame_time_budget_monitor_core ftbm_checker u_ftbm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .over_budget    (over_budget),
    .last_duration  (last_duration),
    .worst_time     (worst_time),
    .undershoot     (undershoot),
    .overshoot      (overshoot),
    .pressure_ratio (pressure_ratio)
);
